### hw/rtl/bolt_pkg.sv
// ----------------------------------------------------------------------------
// bolt_pkg
// Shared types and constants of the bounded ordered list table: request and
// response beats, operation and status codes, store command and compare flags.
// ----------------------------------------------------------------------------
package bolt_pkg;

   localparam int CAPACITY = 16;
   localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   localparam int KEY_W         = 32;
   localparam int REQ_TYPE_W    = 3;
   localparam int INDEX_W       = 4;
   localparam int STATUS_W      = 3;
   localparam int ENTRY_COUNT_W = 5;

   typedef enum logic [REQ_TYPE_W-1:0] {
      OP_SORTED_INS = 3'd0,
      OP_INS_BACK   = 3'd1,
      OP_INS_FRONT  = 3'd2,
      OP_DEL_KEY    = 3'd3,
      OP_DEL_BACK   = 3'd4,
      OP_DEL_FRONT  = 3'd5,
      OP_REVERSE    = 3'd6,
      OP_READ       = 3'd7
   } bolt_op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_DONE      = 3'd0,
      ST_EMPTY     = 3'd1,
      ST_NOT_FOUND = 3'd2,
      ST_FULL      = 3'd3,
      ST_RANGE     = 3'd4
   } bolt_status_type;

   typedef struct packed {
      logic [REQ_TYPE_W-1:0] req_type;
      logic signed [KEY_W-1:0] key;
      logic [INDEX_W-1:0] index;
   } bolt_req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [ENTRY_COUNT_W-1:0] entry_count;
      logic signed [KEY_W-1:0] read_key;
   } bolt_rsp_type;

   typedef struct packed {
      logic wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [KEY_W-1:0] wr_data;
      logic [ADDR_W-1:0] rd_addr;
   } bolt_store_cmd_type;

   typedef struct packed {
      logic ge;
      logic eq;
   } bolt_cmp_type;

endpackage

### hw/rtl/bolt_key_cmp.sv
// ----------------------------------------------------------------------------
// bolt_key_cmp
// Shared key comparator: signed greater-or-equal and equality of a stored
// entry against the request key.
// ----------------------------------------------------------------------------
module bolt_key_cmp (
   input  logic [bolt_pkg::KEY_W-1:0] entry_key,
   input  logic [bolt_pkg::KEY_W-1:0] ref_key,
   output bolt_pkg::bolt_cmp_type     result
);

   assign result.ge = ($signed(entry_key) >= $signed(ref_key));
   assign result.eq = (entry_key == ref_key);

endmodule

### hw/rtl/bolt_key_store.sv
// ----------------------------------------------------------------------------
// bolt_key_store
// Key memory: one write port and one read port, read data registered.
// Contents are not cleared by reset.
// ----------------------------------------------------------------------------
module bolt_key_store (
   input  logic                           clock,
   input  bolt_pkg::bolt_store_cmd_type   cmd,
   output logic [bolt_pkg::KEY_W-1:0]     rd_data_ff
);

   logic [bolt_pkg::KEY_W-1:0] mem [bolt_pkg::CAPACITY];

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[cmd.wr_addr] <= cmd.wr_data;
      end
      rd_data_ff <= mem[cmd.rd_addr];
   end

endmodule

### hw/rtl/bounded_ordered_list_table_unit.sv
// Operation: an insert walks the store from slot 0, or from the count for a back
//   insert; a key or front delete walks from slot 0; reverse swaps pairs from
//   both ends; rejected requests and back delete answer straight from idle.
// Requests: taken only while idle; busy stays high while the sequencer walks
//   the store, one entry through the shared comparator per cycle.
// Reset: synchronous, clears the entry count and control; keys are not cleared.
// ----------------------------------------------------------------------------
// bounded_ordered_list_table_unit
// Ordered list of signed keys in a bounded store, updated by a sequencer that
// ripples entries through a one-write, one-read-port memory and a shared comparator.
// ----------------------------------------------------------------------------
module bounded_ordered_list_table_unit (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  bolt_pkg::bolt_req_type req_payload,
   output logic                   rsp_strobe,
   output bolt_pkg::bolt_rsp_type rsp_payload
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_INS,
      S_DEL,
      S_REV_HI,
      S_REV_WLO,
      S_REV_WHI,
      S_READ
   } state_type;

   state_type state_ff, state_in;
   logic [bolt_pkg::CNT_W-1:0]  count_ff, count_in;
   logic [bolt_pkg::CNT_W-1:0]  ptr_ff, ptr_in;
   logic                        found_ff, found_in;
   logic [bolt_pkg::KEY_W-1:0]  carry_ff, carry_in;
   logic [bolt_pkg::KEY_W-1:0]  key_ff, key_in;
   logic [bolt_pkg::KEY_W-1:0]  tmp_ff, tmp_in;
   logic [bolt_pkg::ADDR_W-1:0] lo_ff, lo_in;
   logic [bolt_pkg::ADDR_W-1:0] hi_ff, hi_in;
   bolt_pkg::bolt_op_type       op_ff, op_in;
   bolt_pkg::bolt_rsp_type      rsp_ff, rsp_in;
   logic                        rsp_strobe_ff, rsp_strobe_in;

   bolt_pkg::bolt_store_cmd_type store_cmd;
   bolt_pkg::bolt_cmp_type       cmp;
   logic [bolt_pkg::KEY_W-1:0]   rd_data_ff;

   bolt_key_store u_store (
      .clock      (clock),
      .cmd        (store_cmd),
      .rd_data_ff (rd_data_ff)
   );

   bolt_key_cmp u_cmp (
      .entry_key (rd_data_ff),
      .ref_key   (key_ff),
      .result    (cmp)
   );

   always_comb begin
      logic                        hit;
      logic                        full;
      logic                        empty;
      logic                        idx_ok;
      logic [bolt_pkg::CNT_W-1:0]  rd_ptr;
      logic [bolt_pkg::ADDR_W-1:0] lo_next;
      logic [bolt_pkg::ADDR_W-1:0] hi_next;

      state_in      = state_ff;
      count_in      = count_ff;
      ptr_in        = ptr_ff;
      found_in      = found_ff;
      carry_in      = carry_ff;
      key_in        = key_ff;
      tmp_in        = tmp_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      op_in         = op_ff;
      rsp_in        = rsp_ff;
      rsp_strobe_in = 1'b0;
      store_cmd     = '0;
      rd_ptr        = '0;
      hit           = 1'b0;
      lo_next       = bolt_pkg::ADDR_W'(lo_ff + 1'b1);
      hi_next       = bolt_pkg::ADDR_W'(hi_ff - 1'b1);
      full          = (count_ff == bolt_pkg::CNT_W'(bolt_pkg::CAPACITY));
      empty         = (count_ff == '0);
      idx_ok        = (32'(req_payload.index) < 32'(count_ff))
                      && (32'(req_payload.index) < bolt_pkg::CAPACITY);

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               key_in             = req_payload.key;
               op_in              = bolt_pkg::bolt_op_type'(req_payload.req_type);
               found_in           = 1'b0;
               ptr_in             = '0;
               rsp_in.status      = bolt_pkg::ST_DONE;
               rsp_in.entry_count = bolt_pkg::ENTRY_COUNT_W'(count_ff);
               rsp_in.read_key    = '0;
               unique case (bolt_pkg::bolt_op_type'(req_payload.req_type))
                  bolt_pkg::OP_SORTED_INS, bolt_pkg::OP_INS_FRONT,
                  bolt_pkg::OP_INS_BACK: begin
                     if (full) begin
                        rsp_in.status = bolt_pkg::ST_FULL;
                        rsp_strobe_in = 1'b1;
                     end else begin
                        // back insert skips straight to the tail slot
                        if (req_payload.req_type == bolt_pkg::OP_INS_BACK) begin
                           ptr_in = count_ff;
                        end
                        rd_ptr   = ptr_in;
                        state_in = S_INS;
                     end
                  end
                  bolt_pkg::OP_DEL_KEY, bolt_pkg::OP_DEL_FRONT: begin
                     if (empty) begin
                        rsp_in.status = bolt_pkg::ST_EMPTY;
                        rsp_strobe_in = 1'b1;
                     end else begin
                        rd_ptr   = '0;
                        state_in = S_DEL;
                     end
                  end
                  bolt_pkg::OP_DEL_BACK: begin
                     if (empty) begin
                        rsp_in.status = bolt_pkg::ST_EMPTY;
                     end else begin
                        count_in           = count_ff - 1'b1;
                        rsp_in.entry_count = bolt_pkg::ENTRY_COUNT_W'(count_in);
                     end
                     rsp_strobe_in = 1'b1;
                  end
                  bolt_pkg::OP_REVERSE: begin
                     if (count_ff > bolt_pkg::CNT_W'(1)) begin
                        lo_in    = '0;
                        hi_in    = bolt_pkg::ADDR_W'(count_ff - 1'b1);
                        rd_ptr   = '0;
                        state_in = S_REV_HI;
                     end else begin
                        rsp_strobe_in = 1'b1;
                     end
                  end
                  bolt_pkg::OP_READ: begin
                     if (idx_ok) begin
                        rd_ptr   = bolt_pkg::CNT_W'(req_payload.index);
                        state_in = S_READ;
                     end else begin
                        rsp_in.status = bolt_pkg::ST_RANGE;
                        rsp_strobe_in = 1'b1;
                     end
                  end
               endcase
            end
         end

         S_INS: begin
            // ripple: drop the new key at the hit slot, then push each old
            // entry one slot toward the back
            hit = (ptr_ff == count_ff) || (op_ff == bolt_pkg::OP_INS_FRONT)
                  || ((op_ff == bolt_pkg::OP_SORTED_INS) && cmp.ge);
            if (found_ff) begin
               store_cmd.wr_en   = 1'b1;
               store_cmd.wr_addr = bolt_pkg::ADDR_W'(ptr_ff);
               store_cmd.wr_data = carry_ff;
               carry_in          = rd_data_ff;
            end else if (hit) begin
               store_cmd.wr_en   = 1'b1;
               store_cmd.wr_addr = bolt_pkg::ADDR_W'(ptr_ff);
               store_cmd.wr_data = key_ff;
               carry_in          = rd_data_ff;
               found_in          = 1'b1;
            end
            if (ptr_ff == count_ff) begin
               count_in           = count_ff + 1'b1;
               rsp_in.status      = bolt_pkg::ST_DONE;
               rsp_in.entry_count = bolt_pkg::ENTRY_COUNT_W'(count_in);
               rsp_strobe_in      = 1'b1;
               state_in           = S_IDLE;
            end else begin
               ptr_in = ptr_ff + 1'b1;
               rd_ptr = ptr_in;
            end
         end

         S_DEL: begin
            // after the match, pull each later entry one slot toward the front
            hit = (op_ff == bolt_pkg::OP_DEL_FRONT) || cmp.eq;
            if (found_ff) begin
               store_cmd.wr_en   = 1'b1;
               store_cmd.wr_addr = bolt_pkg::ADDR_W'(ptr_ff - 1'b1);
               store_cmd.wr_data = rd_data_ff;
            end else if (hit) begin
               found_in = 1'b1;
            end
            if (ptr_ff == count_ff - 1'b1) begin
               if (found_ff || hit) begin
                  count_in      = count_ff - 1'b1;
                  rsp_in.status = bolt_pkg::ST_DONE;
               end else begin
                  rsp_in.status = bolt_pkg::ST_NOT_FOUND;
               end
               rsp_in.entry_count = bolt_pkg::ENTRY_COUNT_W'(count_in);
               rsp_strobe_in      = 1'b1;
               state_in           = S_IDLE;
            end else begin
               ptr_in = ptr_ff + 1'b1;
               rd_ptr = ptr_in;
            end
         end

         S_REV_HI: begin
            tmp_in   = rd_data_ff;
            rd_ptr   = bolt_pkg::CNT_W'(hi_ff);
            state_in = S_REV_WLO;
         end

         S_REV_WLO: begin
            store_cmd.wr_en   = 1'b1;
            store_cmd.wr_addr = lo_ff;
            store_cmd.wr_data = rd_data_ff;
            state_in          = S_REV_WHI;
         end

         S_REV_WHI: begin
            store_cmd.wr_en   = 1'b1;
            store_cmd.wr_addr = hi_ff;
            store_cmd.wr_data = tmp_ff;
            lo_in             = lo_next;
            hi_in             = hi_next;
            if (lo_next < hi_next) begin
               rd_ptr   = bolt_pkg::CNT_W'(lo_next);
               state_in = S_REV_HI;
            end else begin
               rsp_strobe_in = 1'b1;
               state_in      = S_IDLE;
            end
         end

         S_READ: begin
            rsp_in.read_key = rd_data_ff;
            rsp_strobe_in   = 1'b1;
            state_in        = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      store_cmd.rd_addr = bolt_pkg::ADDR_W'(rd_ptr);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         found_ff      <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         found_ff      <= found_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      ptr_ff   <= ptr_in;
      carry_ff <= carry_in;
      key_ff   <= key_in;
      tmp_ff   <= tmp_in;
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      op_ff    <= op_in;
      rsp_ff   <= rsp_in;
   end

   assign busy        = (state_ff != S_IDLE);
   assign rsp_strobe  = rsp_strobe_ff;
   assign rsp_payload = rsp_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= bolt_pkg::CNT_W'(bolt_pkg::CAPACITY))
      else $error("entry count above capacity");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      !reset |=> (count_ff == $past(count_ff) || count_ff == $past(count_ff) + 1'b1
                  || count_ff == $past(count_ff) - 1'b1))
      else $error("entry count moved by more than one");

   a_strobe_source: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ($past(start && !busy) || $past(busy)))
      else $error("response beat without a request");

   a_no_idle_write: assert property (@(posedge clock) disable iff (reset)
      store_cmd.wr_en |-> busy)
      else $error("store written while idle");

   a_ptr_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_INS || state_ff == S_DEL) |-> (ptr_ff <= count_ff))
      else $error("walk pointer past entry count");

endmodule

### tb/tb_bounded_ordered_list_table_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_bounded_ordered_list_table_unit
// Self-checking bench for the ordered key list: every request beat is mirrored
// in a shadow copy of the list, and each response beat is checked field by
// field against the predicted status, entry count and read key.
// ----------------------------------------------------------------------------
module tb_bounded_ordered_list_table_unit;

   localparam logic signed [bolt_pkg::KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
   localparam logic signed [bolt_pkg::KEY_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;

   logic                   clock;
   logic                   reset;
   logic                   start;
   logic                   busy;
   bolt_pkg::bolt_req_type req_payload;
   logic                   rsp_strobe;
   bolt_pkg::bolt_rsp_type rsp_payload;

   // shadow copy of the list
   logic signed [bolt_pkg::KEY_W-1:0] shadow_keys [bolt_pkg::CAPACITY];
   int                                shadow_count;

   bolt_pkg::bolt_rsp_type expected_rsp_q [$];
   int                     fail_count;
   int                     request_count;
   int                     checked_count;
   int                     peak_count;
   int                     status_tally [5];
   bit                     idle_on;

   bounded_ordered_list_table_unit DUT (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   function automatic void insert_key(int pos, logic signed [bolt_pkg::KEY_W-1:0] k);
      for (int i = shadow_count; i > pos; i--)
         shadow_keys[i] = shadow_keys[i-1];
      shadow_keys[pos] = k;
      shadow_count++;
   endfunction

   function automatic void remove_key(int pos);
      for (int i = pos; i + 1 < shadow_count; i++)
         shadow_keys[i] = shadow_keys[i+1];
      shadow_count--;
   endfunction

   // Apply one request to the shadow list and return the response it causes.
   function automatic bolt_pkg::bolt_rsp_type predict_list_op(bolt_pkg::bolt_req_type r);
      bolt_pkg::bolt_rsp_type            rsp;
      int                                pos;
      int                                lo;
      int                                hi;
      logic signed [bolt_pkg::KEY_W-1:0] swap_key;
      rsp = '0;
      rsp.status = bolt_pkg::ST_DONE;
      case (r.req_type)
         bolt_pkg::OP_SORTED_INS: begin
            if (shadow_count >= bolt_pkg::CAPACITY) begin
               rsp.status = bolt_pkg::ST_FULL;
            end else begin
               pos = 0;
               while (pos < shadow_count && shadow_keys[pos] < r.key)
                  pos++;
               insert_key(pos, r.key);
            end
         end
         bolt_pkg::OP_INS_BACK, bolt_pkg::OP_INS_FRONT: begin
            if (shadow_count >= bolt_pkg::CAPACITY)
               rsp.status = bolt_pkg::ST_FULL;
            else
               insert_key((r.req_type == bolt_pkg::OP_INS_BACK) ? shadow_count : 0,
                          r.key);
         end
         bolt_pkg::OP_DEL_KEY: begin
            if (shadow_count == 0) begin
               rsp.status = bolt_pkg::ST_EMPTY;
            end else begin
               pos = 0;
               while (pos < shadow_count && shadow_keys[pos] != r.key)
                  pos++;
               if (pos < shadow_count)
                  remove_key(pos);
               else
                  rsp.status = bolt_pkg::ST_NOT_FOUND;
            end
         end
         bolt_pkg::OP_DEL_BACK, bolt_pkg::OP_DEL_FRONT: begin
            if (shadow_count == 0)
               rsp.status = bolt_pkg::ST_EMPTY;
            else
               remove_key((r.req_type == bolt_pkg::OP_DEL_BACK) ? shadow_count - 1 : 0);
         end
         bolt_pkg::OP_REVERSE: begin
            lo = 0;
            hi = shadow_count - 1;
            while (lo < hi) begin
               swap_key = shadow_keys[lo];
               shadow_keys[lo] = shadow_keys[hi];
               shadow_keys[hi] = swap_key;
               lo++;
               hi--;
            end
         end
         default: begin
            if (int'(r.index) < shadow_count)
               rsp.read_key = shadow_keys[r.index];
            else
               rsp.status = bolt_pkg::ST_RANGE;
         end
      endcase
      rsp.entry_count = bolt_pkg::ENTRY_COUNT_W'(shadow_count);
      status_tally[rsp.status]++;
      if (shadow_count > peak_count)
         peak_count = shadow_count;
      return rsp;
   endfunction

   // Drive one request beat, hold it until accepted, then maybe pause.
   task automatic send_request(bolt_pkg::bolt_op_type op,
                               logic signed [bolt_pkg::KEY_W-1:0] k,
                               logic [bolt_pkg::INDEX_W-1:0] idx);
      bolt_pkg::bolt_req_type r;
      int                     gap;
      r.req_type = op;
      r.key      = k;
      r.index    = idx;
      @(negedge clock);
      start       <= 1'b1;
      req_payload <= r;
      do
         @(posedge clock);
      while (busy);
      expected_rsp_q.push_back(predict_list_op(r));
      request_count++;
      if (idle_on && $urandom_range(0, 2) == 0) begin
         gap = $urandom_range(1, 19);
         @(negedge clock);
         start <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   function automatic logic signed [bolt_pkg::KEY_W-1:0] pick_key();
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 35)
         return $signed($urandom_range(0, 6)) - 3;
      else if (sel < 55 && shadow_count > 0)
         return shadow_keys[$urandom_range(0, shadow_count - 1)];
      else if (sel < 65)
         case ($urandom_range(0, 4))
            0: return KEY_MIN;
            1: return KEY_MAX;
            2: return -1;
            3: return 1;
            default: return 0;
         endcase
      return $urandom;
   endfunction

   // mode 0 favors growth, 1 favors shrinking, 2 is an even mix
   function automatic bolt_pkg::bolt_op_type choose_op(int mode);
      int sel;
      sel = $urandom_range(0, 99);
      case (mode)
         0: begin
            if (sel < 35) return bolt_pkg::OP_SORTED_INS;
            if (sel < 50) return bolt_pkg::OP_INS_BACK;
            if (sel < 62) return bolt_pkg::OP_INS_FRONT;
         end
         1: begin
            if (sel < 8)  return bolt_pkg::OP_SORTED_INS;
            if (sel < 12) return bolt_pkg::OP_INS_BACK;
            if (sel < 16) return bolt_pkg::OP_INS_FRONT;
            if (sel < 40) return bolt_pkg::OP_DEL_KEY;
            if (sel < 52) return bolt_pkg::OP_DEL_BACK;
            if (sel < 64) return bolt_pkg::OP_DEL_FRONT;
         end
         default: ;
      endcase
      return bolt_pkg::bolt_op_type'($urandom_range(0, 7));
   endfunction

   function automatic logic [bolt_pkg::INDEX_W-1:0] pick_index();
      if (shadow_count > 0 && $urandom_range(0, 3) != 0)
         return bolt_pkg::INDEX_W'($urandom_range(0, shadow_count - 1));
      return bolt_pkg::INDEX_W'($urandom_range(0, 15));
   endfunction

   task automatic test_empty_store();
      send_request(bolt_pkg::OP_READ, 0, 4'd0);
      send_request(bolt_pkg::OP_DEL_KEY, 0, 4'd0);
      send_request(bolt_pkg::OP_DEL_BACK, 0, 4'd0);
      send_request(bolt_pkg::OP_DEL_FRONT, 0, 4'd0);
      send_request(bolt_pkg::OP_REVERSE, 0, 4'd0);
   endtask

   task automatic test_single_entry();
      send_request(bolt_pkg::OP_INS_FRONT, KEY_MIN, 4'hF);
      send_request(bolt_pkg::OP_REVERSE, KEY_MAX, 4'd0);
      send_request(bolt_pkg::OP_READ, 0, 4'd0);
      send_request(bolt_pkg::OP_READ, 0, 4'd1);
      send_request(bolt_pkg::OP_DEL_KEY, 7, 4'd0);
   endtask

   task automatic test_sorted_edges();
      // no key greater or equal: lands at the back
      send_request(bolt_pkg::OP_SORTED_INS, KEY_MAX, 4'd0);
      // tie with the minimum: goes before the equal key
      send_request(bolt_pkg::OP_SORTED_INS, KEY_MIN, 4'd0);
      send_request(bolt_pkg::OP_SORTED_INS, 0, 4'd0);
      send_request(bolt_pkg::OP_INS_BACK, -1, 4'd0);
      send_request(bolt_pkg::OP_READ, 0, 4'd2);
      send_request(bolt_pkg::OP_DEL_KEY, KEY_MIN, 4'd0);
      send_request(bolt_pkg::OP_DEL_FRONT, 0, 4'd0);
      send_request(bolt_pkg::OP_DEL_BACK, 0, 4'd0);
   endtask

   task automatic test_full_store();
      while (shadow_count < bolt_pkg::CAPACITY)
         send_request(bolt_pkg::OP_INS_BACK, $urandom, 4'd0);
      send_request(bolt_pkg::OP_SORTED_INS, 5, 4'd0);
      send_request(bolt_pkg::OP_INS_BACK, 5, 4'd0);
      send_request(bolt_pkg::OP_INS_FRONT, 5, 4'd0);
      send_request(bolt_pkg::OP_READ, 0, 4'hF);
      send_request(bolt_pkg::OP_REVERSE, 0, 4'd0);
      send_request(bolt_pkg::OP_READ, 0, 4'd0);
   endtask

   task automatic test_random_traffic(int n_items);
      int mode;
      mode = 2;
      for (int i = 0; i < n_items; i++) begin
         if (i % 30 == 0) begin
            if (shadow_count <= 2)
               mode = 0;
            else if (shadow_count >= bolt_pkg::CAPACITY - 2)
               mode = 1;
            else
               mode = $urandom_range(0, 2);
         end
         if (i % 50 == 0)
            idle_on = (n_items - i > 120) && ($urandom_range(0, 2) != 0);
         send_request(choose_op(mode), pick_key(), pick_index());
      end
   endtask

   always @(posedge clock) begin : rsp_check
      bolt_pkg::bolt_rsp_type exp_rsp;
      if (!reset && rsp_strobe) begin
         if (expected_rsp_q.size() == 0) begin
            $error("response beat with no request outstanding");
            fail_count++;
         end else begin
            exp_rsp = expected_rsp_q.pop_front();
            checked_count++;
            if (rsp_payload.status !== exp_rsp.status) begin
               $error("status: expected %0d, actual %0d", exp_rsp.status,
                      rsp_payload.status);
               fail_count++;
            end
            if (rsp_payload.entry_count !== exp_rsp.entry_count) begin
               $error("entry_count: expected %0d, actual %0d", exp_rsp.entry_count,
                      rsp_payload.entry_count);
               fail_count++;
            end
            if (rsp_payload.read_key !== exp_rsp.read_key) begin
               $error("read_key: expected %0d, actual %0d", exp_rsp.read_key,
                      rsp_payload.read_key);
               fail_count++;
            end
         end
      end
   end

   initial begin
      start        = 1'b0;
      req_payload  = '0;
      reset        = 1'b1;
      shadow_count = 0;
      fail_count   = 0;
      request_count = 0;
      checked_count = 0;
      peak_count   = 0;
      idle_on      = 1'b1;
      foreach (status_tally[i])
         status_tally[i] = 0;
      foreach (shadow_keys[i])
         shadow_keys[i] = '0;
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      test_empty_store();
      test_single_entry();
      test_sorted_edges();
      test_full_store();
      test_random_traffic(620);

      @(negedge clock);
      start <= 1'b0;
      while (expected_rsp_q.size() != 0)
         @(posedge clock);
      repeat (40) @(posedge clock);

      $display("Ran %0d requests, %0d responses checked, peak list size %0d.",
               request_count, checked_count, peak_count);
      $display("Full drops %0d, empty deletes %0d, key misses %0d, range misses %0d.",
               status_tally[bolt_pkg::ST_FULL], status_tally[bolt_pkg::ST_EMPTY],
               status_tally[bolt_pkg::ST_NOT_FOUND], status_tally[bolt_pkg::ST_RANGE]);
      if (fail_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
